[sv/wis_pkg.sv]
// Shared constants and types of the weighted index sampler.
`timescale 1ns / 1ps

package wis_pkg;

  // Function codes of an input item.
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_DRAW  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Work kinds that the front hands to the back.
  localparam logic [1:0] K_IMM   = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_DRAW  = 2'd2;

  // Width of the index field on the result channel.
  localparam int OUT_IDX_W = 10;

  // Number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Control part of one queued work entry.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
  } ctrl_t;

endpackage

[sv/wis_front.sv]
// Front end: accepts items, keeps entry count and running total, classifies work.
`timescale 1ns / 1ps

module wis_front #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_func,
  input  logic [31:0]                          in_weight,
  input  logic [31:0]                          in_random_fraction,
  output logic                                 q_valid,
  input  logic                                 q_stall,
  output wis_pkg::ctrl_t                       q_ctrl,
  output logic [$clog2(MAX_ENTRIES)-1:0]       q_idx,
  output logic [((WEIGHT_BITS > 32) ? 32 : WEIGHT_BITS) + $clog2(MAX_ENTRIES)-1:0] q_data,
  output logic [31:0]                          q_u
);

  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int EFF_W = (WEIGHT_BITS > 32) ? 32 : WEIGHT_BITS;
  localparam int SUM_W = EFF_W + IW;

  logic [CW-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic [SUM_W-1:0] sum_c;
  logic             accept;

  assign accept   = in_valid && !q_stall;
  assign in_stall = q_stall;
  assign q_valid  = in_valid;
  assign q_u      = in_random_fraction;
  assign sum_c    = total_r + SUM_W'(in_weight[EFF_W-1:0]);

  // Classify the item and update the count and total on acceptance.
  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    q_ctrl.kind   = wis_pkg::K_IMM;
    q_ctrl.status = wis_pkg::ST_OK;
    q_idx         = '0;
    q_data        = total_r;
    case (in_func)
      wis_pkg::FN_LOAD: begin
        if (count_r == CW'(MAX_ENTRIES)) begin
          q_ctrl.status = wis_pkg::ST_FULL;
          q_idx         = IW'(MAX_ENTRIES - 1);
        end else begin
          q_ctrl.kind = wis_pkg::K_WRITE;
          q_idx       = count_r[IW-1:0];
          q_data      = sum_c;
          if (accept) begin
            count_nxt = count_r + CW'(1);
            total_nxt = sum_c;
          end
        end
      end
      wis_pkg::FN_DRAW: begin
        if (count_r == '0) begin
          q_ctrl.status = wis_pkg::ST_EMPTY;
        end else begin
          // The search range ends at the last loaded entry.
          q_ctrl.kind = wis_pkg::K_DRAW;
          q_idx       = IW'(count_r - CW'(1));
        end
      end
      wis_pkg::FN_CLEAR: begin
        if (accept) begin
          count_nxt = '0;
          total_nxt = '0;
        end
      end
      default: begin
        // Unused function code: plain ok result, no state change.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else begin
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

[sv/wis_queue.sv]
// Small register queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module wis_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_stall,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_take,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     fill_r, fill_nxt;
  logic              push, pop;

  assign push_stall = (fill_r == NW'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_take;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + NW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/wis_back.sv]
// Back end: prefix-sum table, scaled target and binary search, result register.
`timescale 1ns / 1ps

module wis_back #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_take,
  input  wis_pkg::ctrl_t                       q_ctrl,
  input  logic [$clog2(MAX_ENTRIES)-1:0]       q_idx,
  input  logic [((WEIGHT_BITS > 32) ? 32 : WEIGHT_BITS) + $clog2(MAX_ENTRIES)-1:0] q_data,
  input  logic [31:0]                          q_u,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wis_pkg::OUT_IDX_W-1:0]        out_index,
  output logic [1:0]                           out_status
);

  localparam int IW     = $clog2(MAX_ENTRIES);
  localparam int EFF_W  = (WEIGHT_BITS > 32) ? 32 : WEIGHT_BITS;
  localparam int SUM_W  = EFF_W + IW;
  localparam int EXT_W  = (SUM_W > 32) ? SUM_W : 33;
  localparam int HI_W   = EXT_W - 32;
  localparam int ADD_W  = HI_W + 33;
  localparam int OUT_IW = wis_pkg::OUT_IDX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;

  logic [SUM_W-1:0] mem [MAX_ENTRIES];

  logic [2:0]          state_r, state_nxt;
  logic [SUM_W-1:0]    tot_r, tot_nxt;
  logic [31:0]         u_r, u_nxt;
  logic [63:0]         prod_lo_r, prod_lo_nxt;
  logic [HI_W+31:0]    prod_hi_r, prod_hi_nxt;
  logic [SUM_W-1:0]    target_r, target_nxt;
  logic [IW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [SUM_W-1:0]    rd_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_IW-1:0]   out_index_r, out_index_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic                out_free;
  logic [EXT_W-1:0]    tot_ext;
  logic [ADD_W-1:0]    target_sum;
  logic [IW-1:0]       lo_c, hi_c;
  logic [IW:0]         mid_sum;
  logic                rd_en, wr_en;

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign tot_ext    = EXT_W'(tot_r);
  assign target_sum = ADD_W'(prod_hi_r) + ADD_W'(prod_lo_r[63:32]);

  // Search step: narrow the range from the entry read last cycle.
  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (rd_pend_r) begin
      if (rd_data_r >= target_r) begin
        hi_c = mid_r;
      end else begin
        lo_c = mid_r + IW'(1);
      end
    end
  end

  assign mid_sum = ({1'b0, lo_c} + {1'b0, hi_c}) >> 1;

  // Sequencer of the back end.
  always_comb begin
    state_nxt      = state_r;
    tot_nxt        = tot_r;
    u_nxt          = u_r;
    prod_lo_nxt    = prod_lo_r;
    prod_hi_nxt    = prod_hi_r;
    target_nxt     = target_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    rd_pend_nxt    = rd_pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    q_take         = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_take = 1'b1;
          case (q_ctrl.kind)
            wis_pkg::K_WRITE: begin
              wr_en          = 1'b1;
              out_valid_nxt  = 1'b1;
              out_index_nxt  = OUT_IW'(q_idx);
              out_status_nxt = wis_pkg::ST_OK;
            end
            wis_pkg::K_DRAW: begin
              tot_nxt   = q_data;
              u_nxt     = q_u;
              lo_nxt    = '0;
              hi_nxt    = q_idx;
              state_nxt = S_MUL_LO;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_index_nxt  = OUT_IW'(q_idx);
              out_status_nxt = q_ctrl.status;
            end
          endcase
        end
      end
      S_MUL_LO: begin
        // Low 32 bits of the total times the fraction.
        prod_lo_nxt = 64'(tot_ext[31:0]) * 64'(u_r);
        state_nxt   = S_MUL_HI;
      end
      S_MUL_HI: begin
        // High part of the total times the fraction.
        prod_hi_nxt = (HI_W + 32)'(tot_ext[EXT_W-1:32]) * (HI_W + 32)'(u_r);
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        target_nxt  = target_sum[SUM_W-1:0];
        rd_pend_nxt = 1'b0;
        state_nxt   = S_SEARCH;
      end
      S_SEARCH: begin
        lo_nxt      = lo_c;
        hi_nxt      = hi_c;
        rd_pend_nxt = 1'b0;
        if (lo_c == hi_c) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_index_nxt  = OUT_IW'(lo_c);
            out_status_nxt = wis_pkg::ST_OK;
            state_nxt      = S_IDLE;
          end
        end else begin
          rd_en       = 1'b1;
          mid_nxt     = mid_sum[IW-1:0];
          rd_pend_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    tot_r        <= tot_nxt;
    u_r          <= u_nxt;
    prod_lo_r    <= prod_lo_nxt;
    prod_hi_r    <= prod_hi_nxt;
    target_r     <= target_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

  // Prefix-sum table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_idx] <= q_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[mid_sum[IW-1:0]];
    end
  end

endmodule

[sv/weighted_index_sampler_unit.sv]
// Top level of the weighted index sampler: front end, queue and back end.
`timescale 1ns / 1ps

// Discrete sampler by inverse cumulative distribution. A load item appends a
// weight and stores the running prefix sum; a clear item empties the table; a
// draw item scales the total by the 32-bit fraction and returns the first entry
// whose prefix sum is not below that target, clamped to the last loaded entry.
// Load, clear and status-only items are answered by the back end without a search. A
// draw first scales the total by the fraction in a low multiply, a high multiply and
// a sum, then takes one binary-search step per cycle, each step being one read of
// the single prefix-sum memory port. A two-entry queue lets the input side keep
// taking items while a draw is searched. Table contents are undefined after reset;
// the entry count limits all reads to written entries, so no clearing pass is
// needed.

module weighted_index_sampler_unit #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_weight,
  input  logic [31:0] in_random_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_index,
  output logic [1:0]  out_status
);

  localparam int IW     = $clog2(MAX_ENTRIES);
  localparam int EFF_W  = (WEIGHT_BITS > 32) ? 32 : WEIGHT_BITS;
  localparam int SUM_W  = EFF_W + IW;
  localparam int CTRL_W = $bits(wis_pkg::ctrl_t);
  localparam int DATA_W = CTRL_W + IW + SUM_W + 32;

  wis_pkg::ctrl_t   f_ctrl, b_ctrl;
  logic [IW-1:0]    f_idx, b_idx;
  logic [SUM_W-1:0] f_data, b_data;
  logic [31:0]      f_u, b_u;
  logic             f_valid, f_stall;
  logic             b_valid, b_take;
  logic [DATA_W-1:0] push_word, pop_word;

  wis_front #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_weight         (in_weight),
    .in_random_fraction(in_random_fraction),
    .q_valid           (f_valid),
    .q_stall           (f_stall),
    .q_ctrl            (f_ctrl),
    .q_idx             (f_idx),
    .q_data            (f_data),
    .q_u               (f_u)
  );

  // Pack one work entry for the queue.
  assign push_word = {f_ctrl, f_idx, f_data, f_u};

  wis_queue #(
    .DATA_W(DATA_W),
    .DEPTH (wis_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_stall(f_stall),
    .push_data (push_word),
    .pop_valid (b_valid),
    .pop_take  (b_take),
    .pop_data  (pop_word)
  );

  assign {b_ctrl, b_idx, b_data, b_u} = pop_word;

  wis_back #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_take    (b_take),
    .q_ctrl    (b_ctrl),
    .q_idx     (b_idx),
    .q_data    (b_data),
    .q_u       (b_u),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_index (out_index),
    .out_status(out_status)
  );

endmodule
